/* hdl/atps_pkg.sv */
// Package for the accelerometer tilt smoother: widths, constants, arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package atps_pkg;
	localparam int CordicSteps = 16;
	localparam int AngleFracBits = 8;
	localparam int TableFracBits = 24;
	localparam int DW = 48;
	localparam int AW = 34;

	localparam logic [4:0] RegSwapAxes = 5'd0;
	localparam logic [4:0] RegMirrorPitch = 5'd4;
	localparam logic [4:0] RegMirrorRoll = 5'd8;
	localparam logic [4:0] RegPitchOffset = 5'd12;
	localparam logic [4:0] RegRollOffset = 5'd16;

	function automatic logic [AW-1:0] atan_q24(input logic [4:0] i);
		case (i)
			5'd0: atan_q24 = 34'd754974720;
			5'd1: atan_q24 = 34'd445687602;
			5'd2: atan_q24 = 34'd235489088;
			5'd3: atan_q24 = 34'd119537938;
			5'd4: atan_q24 = 34'd60000934;
			5'd5: atan_q24 = 34'd30029717;
			5'd6: atan_q24 = 34'd15018523;
			5'd7: atan_q24 = 34'd7509720;
			5'd8: atan_q24 = 34'd3754917;
			5'd9: atan_q24 = 34'd1877466;
			5'd10: atan_q24 = 34'd938734;
			5'd11: atan_q24 = 34'd469367;
			5'd12: atan_q24 = 34'd234684;
			5'd13: atan_q24 = 34'd117342;
			5'd14: atan_q24 = 34'd58671;
			5'd15: atan_q24 = 34'd29335;
			5'd16: atan_q24 = 34'd14668;
			5'd17: atan_q24 = 34'd7334;
			5'd18: atan_q24 = 34'd3667;
			5'd19: atan_q24 = 34'd1833;
			5'd20: atan_q24 = 34'd917;
			5'd21: atan_q24 = 34'd458;
			5'd22: atan_q24 = 34'd229;
			5'd23: atan_q24 = 34'd115;
			default: atan_q24 = '0;
		endcase
	endfunction
endpackage

/* hdl/atps_isqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on atps_pkg.
`timescale 1ns / 1ps
module atps_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root,
	output logic [32:0] rem
);
	import atps_pkg::*;
	logic [63:0] v_q;
	logic [33:0] r_q;
	logic [33:0] rm_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [35:0] trial;
	logic [35:0] shifted;
	assign shifted = {rm_q, v_q[63:62]};
	assign trial = shifted - {r_q, 2'b01};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			r_q <= '0;
			rm_q <= '0;
		end else if (busy_q) begin
			v_q <= {v_q[61:0], 2'b00};
			if (!trial[35]) begin
				rm_q <= trial[33:0];
				r_q <= {r_q[32:0], 1'b1};
			end else begin
				rm_q <= shifted[33:0];
				r_q <= {r_q[32:0], 1'b0};
			end
		end
	end
	assign root = r_q[31:0];
	assign rem = rm_q[32:0];
endmodule

/* hdl/atps_cordic.sv */
// Shared CORDIC vectoring unit, one iteration per cycle, angle in degrees Q24.
// Depends on atps_pkg.
`timescale 1ns / 1ps
module atps_cordic (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [atps_pkg::DW-1:0] yin,
	input  logic signed [atps_pkg::DW-1:0] xin,
	output logic                           done,
	output logic signed [atps_pkg::AW-1:0] angle
);
	import atps_pkg::*;
	logic signed [DW-1:0] x_q, y_q;
	logic signed [AW-1:0] a_q;
	logic [4:0] i_q;
	logic busy_q;
	logic signed [DW-1:0] xs, ys;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(CordicSteps - 1) || y_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			if (xin < 0) begin
				x_q <= -xin;
				y_q <= -yin;
				a_q <= (yin >= 0) ? (AW'(180) <<< TableFracBits)
					: -(AW'(180) <<< TableFracBits);
			end else begin
				x_q <= xin;
				y_q <= yin;
				a_q <= '0;
			end
		end else if (busy_q && y_q != '0) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				a_q <= a_q + $signed(atan_q24(i_q));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				a_q <= a_q - $signed(atan_q24(i_q));
			end
		end
	end
	assign angle = a_q;
endmodule

/* hdl/accel_tilt_pitch_roll_smoother_unit.sv */
// Top level of the tilt smoother: sequencer, registers, smoothing filter.
// Depends on atps_pkg, atps_isqrt and atps_cordic.
// Steps from the input transfer to a valid result: two root passes, two CORDIC runs
// and a load into the output register.
// A new sample is accepted only in idle, after the previous result has been loaded; a CORDIC
// run that reaches zero ends early, and a zero vector is dropped after the first root pass.
// A result waits in the output register; the block stalls only when the next result
// is ready before the previous one has been taken.
// Asynchronous reset clears registers, filter state and the primed flag.
`timescale 1ns / 1ps
module accel_tilt_pitch_roll_smoother_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata, // accel_x, accel_y, accel_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata, // g_force, raw_pitch, raw_roll, smooth_pitch, smooth_roll
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import atps_pkg::*;
	typedef enum logic [9:0] {
		S_IDLE = 10'd1, S_G = 10'd2, S_GW = 10'd4, S_R = 10'd8, S_RW = 10'd16,
		S_P = 10'd32, S_PW = 10'd64, S_L = 10'd128, S_LW = 10'd256, S_OUT = 10'd512
	} state_t;
	state_t st_q;
	logic swap_q, mp_q, mr_q;
	logic signed [16:0] poff_q, roff_q;
	logic signed [13:0] x_q, y_q, z_q;
	logic [13:0] g_q;
	logic [31:0] r_q;
	logic signed [15:0] rp_q;
	logic signed [16:0] rr_q;
	logic signed [17:0] pf_q, rf_q;
	logic primed_q;
	logic out_v_q;
	logic [87:0] tdata_q;
	logic out_load;
	logic sq_start, sq_done, cd_start, cd_done;
	logic [63:0] rad;
	logic [31:0] root;
	logic [32:0] rem;
	logic signed [DW-1:0] cy, cx;
	logic signed [AW-1:0] ang;
	logic signed [AW-1:0] angr;
	logic signed [27:0] sx2, sy2, sz2;
	logic wr;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0; mp_q <= 1'b0; mr_q <= 1'b0;
			poff_q <= '0; roff_q <= '0;
		end else if (wr) begin
			unique case (paddr)
				RegSwapAxes: swap_q <= pwdata[0];
				RegMirrorPitch: mp_q <= pwdata[0];
				RegMirrorRoll: mr_q <= pwdata[0];
				RegPitchOffset: poff_q <= pwdata[16:0];
				RegRollOffset: roff_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr)
			RegSwapAxes: prdata = {31'd0, swap_q};
			RegMirrorPitch: prdata = {31'd0, mp_q};
			RegMirrorRoll: prdata = {31'd0, mr_q};
			RegPitchOffset: prdata = {{15{poff_q[16]}}, poff_q};
			RegRollOffset: prdata = {{15{roff_q[16]}}, roff_q};
			default: prdata = '0;
		endcase
	end
	assign sx2 = x_q * x_q;
	assign sy2 = y_q * y_q;
	assign sz2 = z_q * z_q;
	assign rad = (st_q == S_G) ? 64'(sx2) + 64'(sy2) + 64'(sz2)
		: {32'(sy2) + 32'(sz2), 32'd0};
	assign sq_start = (st_q == S_G) || (st_q == S_R);
	assign cd_start = (st_q == S_P) || (st_q == S_L);
	assign cy = (st_q == S_P) ? -(DW'(x_q) <<< 16) : (DW'(y_q) <<< 16);
	assign cx = (st_q == S_P) ? DW'({1'b0, r_q}) : (DW'(z_q) <<< 16);
	atps_isqrt u_sqrt (.clk, .arst_n, .start(sq_start), .radicand(rad), .done(sq_done),
		.root, .rem);
	atps_cordic u_cordic (.clk, .arst_n, .start(cd_start), .yin(cy), .xin(cx),
		.done(cd_done), .angle(ang));
	assign angr = (ang + (AW'(1) <<< (TableFracBits - AngleFracBits - 1)))
		>>> (TableFracBits - AngleFracBits);
	function automatic logic signed [17:0] filt(input logic signed [17:0] f,
		input logic signed [18:0] lvl, input logic pr);
		logic signed [27:0] d;
		logic signed [27:0] v;
		begin
			d = (28'(lvl) - 28'(f)) * 28'sd77 + 28'sd128;
			v = pr ? 28'(f) + (d >>> 8) : 28'(lvl);
			if (v > 28'sd131071) filt = 18'sd131071;
			else if (v < -28'sd131072) filt = -18'sd131072;
			else filt = v[17:0];
		end
	endfunction
	logic signed [18:0] lp, lr;
	logic signed [16:0] pm, rm;
	logic signed [16:0] rsrc;
	assign rsrc = (st_q == S_LW) ? 17'(angr) : rr_q;
	assign pm = mp_q ? -17'(rp_q) : 17'(rp_q);
	assign rm = mr_q ? -rsrc : rsrc;
	assign lp = 19'(pm) - 19'(poff_q);
	assign lr = 19'(rm) - 19'(roff_q);
	assign s_axis_tready = (st_q == S_IDLE);
	assign out_load = (st_q == S_OUT) && (!out_v_q || m_axis_tready);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = tdata_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; pf_q <= '0; rf_q <= '0; primed_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (s_axis_tvalid) begin
					st_q <= S_G;
				end
				S_G: st_q <= S_GW;
				S_GW: if (sq_done) begin
					st_q <= (root == '0 && rem == '0) ? S_IDLE : S_R;
				end
				S_R: st_q <= S_RW;
				S_RW: if (sq_done) begin
					st_q <= S_P;
				end
				S_P: st_q <= S_PW;
				S_PW: if (cd_done) begin
					st_q <= S_L;
				end
				S_L: st_q <= S_LW;
				S_LW: if (cd_done) begin
					st_q <= S_OUT;
					pf_q <= filt(pf_q, lp, primed_q);
					rf_q <= filt(rf_q, lr, primed_q);
					primed_q <= 1'b1;
				end
				S_OUT: if (out_load) begin
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && s_axis_tvalid) begin
			x_q <= s_axis_tdata[13:0];
			y_q <= s_axis_tdata[27:14];
			z_q <= s_axis_tdata[41:28];
		end
		if (st_q == S_GW && sq_done) begin
			g_q <= 14'((rem > 33'(root)) ? root + 32'd1 : root);
			if (swap_q) begin
				x_q <= y_q;
				y_q <= x_q;
			end
		end
		if (st_q == S_RW && sq_done) r_q <= root;
		if (st_q == S_PW && cd_done) rp_q <= 16'(angr);
		if (st_q == S_LW && cd_done) rr_q <= 17'(angr);
		if (out_load) tdata_q <= {5'd0, rf_q, pf_q, rm, pm[15:0], g_q};
	end
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result transfer changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n) m_axis_tvalid |-> primed_q)
		else $error("result before filter primed");
endmodule
